/* hw/rtl/mrs_pkg.sv */
`timescale 1ns / 1ps
// Package for the Modbus RTU register slave.
// Types, function codes, exception codes and CRC helper; no dependencies.
package mrs_pkg;

    localparam int HOLDING_COUNT_DEF = 7;
    localparam int INPUT_COUNT_DEF   = 8;
    localparam int FRAME_BYTES_DEF   = 256;
    localparam int IDX_W             = 5;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  EXC_FLAG        = 8'h80;
    localparam logic [15:0] MAX_WRITE_COUNT = 16'd123;

    localparam logic [7:0] FN_RD_HOLD  = 8'h03;
    localparam logic [7:0] FN_RD_INPUT = 8'h04;
    localparam logic [7:0] FN_WR_ONE   = 8'h06;
    localparam logic [7:0] FN_WR_MULTI = 8'h10;

    localparam logic [7:0] EXC_BAD_FUNCTION = 8'h01;
    localparam logic [7:0] EXC_BAD_ADDRESS  = 8'h02;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WR_HI,
        ST_WR_LO,
        ST_WR_ST,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept_en;
        logic serve_init;
        logic single_wr;
        logic wr_hi;
        logic wr_lo;
        logic wr_st;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic frame_done;
        logic drop;
        logic single_ok;
        logic multi_ok;
        logic wr_last;
        logic out_free;
        logic emit_last;
    } stat_t;

    function automatic logic [15:0] holding_rst(input int i);
        logic [15:0] v;
        case (i)
            0:       v = 16'd1;
            1:       v = 16'd50;
            2:       v = 16'd50;
            3:       v = 16'd21000;
            4:       v = 16'd1000;
            5:       v = 16'd8;
            6:       v = 16'd8;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

/* hw/rtl/mrs_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/mrs_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the Modbus RTU register slave.
// Depends on mrs_pkg.
module mrs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  mrs_pkg::stat_t  stat,
    output mrs_pkg::cmd_t   cmd,
    output mrs_pkg::state_t state
);
    import mrs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (stat.frame_done) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.drop) state_next = ST_IDLE;
                else if (stat.multi_ok) state_next = ST_WR_HI;
                else state_next = ST_EMIT;
            end
            ST_WR_HI: state_next = ST_WR_LO;
            ST_WR_LO: state_next = ST_WR_ST;
            ST_WR_ST: begin
                state_next = stat.wr_last ? ST_EMIT : ST_WR_HI;
            end
            ST_EMIT: begin
                if (stat.out_free && stat.emit_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: cmd.accept_en = 1'b1;
            ST_CHECK: begin
                cmd.serve_init = 1'b1;
                cmd.single_wr  = ~stat.drop & stat.single_ok;
            end
            ST_WR_HI: cmd.wr_hi = 1'b1;
            ST_WR_LO: cmd.wr_lo = 1'b1;
            ST_WR_ST: cmd.wr_st = 1'b1;
            ST_EMIT:  cmd.emit_load = stat.out_free;
            default:  cmd = '0;
        endcase
    end

    assign state = state_reg;
endmodule

/* hw/rtl/mrs_dp.sv */
`timescale 1ns / 1ps
// Datapath of the Modbus RTU register slave: frame store, register files,
// request decode, reply byte generation with CRC. Depends on mrs_pkg, mrs_ram.
module mrs_dp #(
    parameter int HOLDING_COUNT = mrs_pkg::HOLDING_COUNT_DEF,
    parameter int INPUT_COUNT   = mrs_pkg::INPUT_COUNT_DEF,
    parameter int FRAME_BYTES   = mrs_pkg::FRAME_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [7:0]                cfg_wr_data,
    input  logic                      s_valid,
    input  logic                      s_op,
    input  logic [7:0]                s_rx_byte,
    input  logic [4:0]                s_reg_index,
    input  logic [15:0]               s_reg_value,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic [7:0]                m_tx_byte,
    output logic                      m_last_byte,
    input  mrs_pkg::cmd_t             cmd,
    output mrs_pkg::stat_t            stat
);
    import mrs_pkg::*;

    localparam int AW  = $clog2(FRAME_BYTES);
    localparam int LW  = $clog2(FRAME_BYTES + 1);
    localparam int HIW = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
    localparam int IIW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;

    logic [7:0]    addr_reg;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_inc;
    logic [7:0]    hdr_reg [7];
    logic [15:0]   hold_reg [HOLDING_COUNT];
    logic [15:0]   inp_reg [INPUT_COUNT];

    logic byte_acc, upd_acc, done;
    logic [9:0] exp_len;

    assign byte_acc = s_valid & cmd.accept_en & ~s_op;
    assign upd_acc  = s_valid & cmd.accept_en & s_op;
    assign len_inc  = len_reg + 1'b1;
    assign exp_len  = (hdr_reg[1] == FN_WR_MULTI) ? (10'd9 + {2'b00, hdr_reg[6]}) : 10'd8;
    assign done     = byte_acc && (10'(len_inc) >= 10'd8) && (10'(len_inc) == exp_len);

    // frame store
    logic          wr_lo_sel;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_q;
    logic [IDX_W-1:0] wi_reg;

    assign ram_raddr = AW'(cmd.wr_lo ? (9'd8 + {3'b000, wi_reg, 1'b0})
                                     : (9'd7 + {3'b000, wi_reg, 1'b0}));
    assign wr_lo_sel = cmd.wr_lo;

    mrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_store (
        .aclk  (aclk),
        .we    (byte_acc),
        .waddr (AW'(len_reg)),
        .wdata (s_rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // request decode
    logic [15:0] start, cnt;
    logic [16:0] sum;
    logic        exc, echo, rd_hold;
    logic [7:0]  exc_code;
    logic [6:0]  body_len;

    assign start = {hdr_reg[2], hdr_reg[3]};
    assign cnt   = {hdr_reg[4], hdr_reg[5]};
    assign sum   = {1'b0, start} + {1'b0, cnt};

    always_comb begin
        exc      = 1'b0;
        exc_code = EXC_BAD_ADDRESS;
        echo     = 1'b0;
        rd_hold  = 1'b0;
        case (hdr_reg[1])
            FN_RD_HOLD: begin
                rd_hold = 1'b1;
                exc     = sum > 17'(HOLDING_COUNT);
            end
            FN_RD_INPUT: exc = sum > 17'(INPUT_COUNT);
            FN_WR_ONE: begin
                echo = 1'b1;
                exc  = start >= 16'(HOLDING_COUNT);
            end
            FN_WR_MULTI: begin
                echo = 1'b1;
                exc  = (cnt == 16'd0) || (cnt > MAX_WRITE_COUNT)
                    || ({9'd0, hdr_reg[6]} != {cnt, 1'b0})
                    || (sum > 17'(HOLDING_COUNT));
            end
            default: begin
                exc      = 1'b1;
                exc_code = EXC_BAD_FUNCTION;
            end
        endcase
    end

    assign body_len = exc ? 7'd3 : (echo ? 7'd6 : (7'd3 + {cnt[5:0], 1'b0}));

    // reply generation
    logic [6:0]       k_reg;
    logic [15:0]      crc_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic             lo_reg;
    logic [7:0]       hi_reg;
    logic [15:0]      file_val;
    logic [7:0]       tx_b;
    logic             tx_last, is_body, is_data;
    logic [IDX_W-1:0] hidx;

    assign file_val = rd_hold
        ? ((32'(ptr_reg) < HOLDING_COUNT) ? hold_reg[HIW'(ptr_reg)] : 16'd0)
        : ((32'(ptr_reg) < INPUT_COUNT) ? inp_reg[IIW'(ptr_reg)] : 16'd0);

    always_comb begin
        tx_b    = 8'd0;
        tx_last = 1'b0;
        is_body = 1'b0;
        is_data = 1'b0;
        if (k_reg == body_len) begin
            tx_b = crc_reg[7:0];
        end else if (k_reg == body_len + 7'd1) begin
            tx_b    = crc_reg[15:8];
            tx_last = 1'b1;
        end else begin
            is_body = 1'b1;
            if (k_reg == 7'd0) tx_b = hdr_reg[0];
            else if (k_reg == 7'd1) tx_b = exc ? (hdr_reg[1] | EXC_FLAG) : hdr_reg[1];
            else if (exc) tx_b = exc_code;
            else if (echo) tx_b = hdr_reg[k_reg[2:0]];
            else if (k_reg == 7'd2) tx_b = {cnt[6:0], 1'b0};
            else begin
                is_data = 1'b1;
                tx_b    = lo_reg ? file_val[7:0] : file_val[15:8];
            end
        end
    end

    assign hidx = start[IDX_W-1:0] + wi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= 8'd1;
            len_reg  <= '0;
            m_valid  <= 1'b0;
            for (int i = 0; i < HOLDING_COUNT; i++) hold_reg[i] <= holding_rst(i);
            for (int i = 0; i < INPUT_COUNT; i++) inp_reg[i] <= 16'd0;
        end else begin
            if (cfg_wr_en) addr_reg <= cfg_wr_data;
            if (byte_acc) begin
                len_reg <= (done || len_inc == LW'(FRAME_BYTES)) ? '0 : len_inc;
                if (len_reg < LW'(7)) hdr_reg[len_reg[2:0]] <= s_rx_byte;
            end
            if (upd_acc && 32'(s_reg_index) < INPUT_COUNT) begin
                inp_reg[IIW'(s_reg_index)] <= s_reg_value;
            end
            if (cmd.single_wr) hold_reg[HIW'(start)] <= cnt;
            if (cmd.wr_st && 32'(hidx) < HOLDING_COUNT) hold_reg[HIW'(hidx)] <= {hi_reg, ram_q};
            if (cmd.emit_load) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.serve_init) begin
            k_reg   <= '0;
            crc_reg <= CRC_INIT;
            ptr_reg <= start[IDX_W-1:0];
            lo_reg  <= 1'b0;
            wi_reg  <= '0;
        end
        if (wr_lo_sel) hi_reg <= ram_q;
        if (cmd.wr_st) wi_reg <= wi_reg + 1'b1;
        if (cmd.emit_load) begin
            m_tx_byte   <= tx_b;
            m_last_byte <= tx_last;
            k_reg       <= k_reg + 7'd1;
            if (is_body) crc_reg <= crc_byte(crc_reg, tx_b);
            if (is_data) begin
                lo_reg <= ~lo_reg;
                if (lo_reg) ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    always_comb begin
        stat            = '0;
        stat.frame_done = done;
        stat.drop       = hdr_reg[0] != addr_reg;
        stat.single_ok  = (hdr_reg[1] == FN_WR_ONE) && !exc;
        stat.multi_ok   = (hdr_reg[1] == FN_WR_MULTI) && !exc;
        stat.wr_last    = (16'(wi_reg) + 16'd1) == cnt;
        stat.out_free   = ~m_valid | m_ready;
        stat.emit_last  = k_reg == body_len + 7'd1;
    end
endmodule

/* hw/rtl/modbus_rtu_register_slave.sv */
`timescale 1ns / 1ps
// Modbus RTU register slave, top level.
// Depends on mrs_pkg, mrs_ctrl, mrs_dp, mrs_ram.
//
// Input channel (s_valid/s_ready): op 0 carries one received frame byte,
// op 1 updates one input register (index at or past the count is ignored).
// A frame completes at 8 bytes, or 9 plus its byte count for function 0x10.
// Result channel (m_valid/m_ready): reply bytes, CRC low byte first,
// m_last_byte marks the final CRC byte. Frames for other stations get no reply.
// Bytes and updates that do not complete a frame leave s_ready high.
// A completed frame passes the decode state, then WR_HI, WR_LO and WR_ST
// per register for a 0x10 write (frame store read port), then the reply bytes
// through the output register; s_ready stays low until the last reply byte
// is loaded. A stalled receiver holds the output register and the sequencer.
// Reset: station address 1, holding registers 1,50,50,21000,1000,8,8,
// input registers zero, frame assembly empty, no clearing pass. The user writes
// the station address (cfg_wr_en/cfg_wr_data) only while idle; unenforced.
module modbus_rtu_register_slave #(
    parameter int HOLDING_COUNT = mrs_pkg::HOLDING_COUNT_DEF,
    parameter int INPUT_COUNT   = mrs_pkg::INPUT_COUNT_DEF,
    parameter int FRAME_BYTES   = mrs_pkg::FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_rx_byte,
    input  logic [4:0]  s_reg_index,
    input  logic [15:0] s_reg_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_last_byte
);
    import mrs_pkg::*;

    cmd_t   cmd;
    stat_t  stat;
    state_t state;

    mrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd),
        .state   (state)
    );

    mrs_dp #(
        .HOLDING_COUNT (HOLDING_COUNT),
        .INPUT_COUNT   (INPUT_COUNT),
        .FRAME_BYTES   (FRAME_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_op        (s_op),
        .s_rx_byte   (s_rx_byte),
        .s_reg_index (s_reg_index),
        .s_reg_value (s_reg_value),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_tx_byte   (m_tx_byte),
        .m_last_byte (m_last_byte),
        .cmd         (cmd),
        .stat        (stat)
    );

    assign s_ready = cmd.accept_en;

    a_frame_to_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && stat.frame_done) |=> (state == ST_CHECK))
        else $error("completed frame did not start decode");

    a_last_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_EMIT && stat.out_free && stat.emit_last) |=>
        (m_valid && m_last_byte && state == ST_IDLE))
        else $error("final reply byte not presented");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == ST_WR_HI || state == ST_WR_LO || state == ST_WR_ST) |-> !cmd.emit_load)
        else $error("reply byte loaded during register write loop");
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for modbus_rtu_register_slave: frame bytes and input
// register updates go in, reply bytes are checked against a behavioral slave.
// Depends on mrs_pkg and the RTL of modbus_rtu_register_slave.
module tb_top;
    import mrs_pkg::*;

    typedef struct {
        bit        op;
        bit [7:0]  rx;
        bit [4:0]  idx;
        bit [15:0] val;
    } item_t;

    typedef struct {
        bit [7:0] data;
        bit       last;
    } reply_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [7:0]  s_rx_byte;
    logic [4:0]  s_reg_index;
    logic [15:0] s_reg_value;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_tx_byte;
    logic        m_last_byte;

    item_t  pending_q[$];
    reply_t reply_q[$];
    int     errors;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     s_taken;
    int     hold_seq;
    int     hold_seen;
    int     hold_cnt;
    int     item_cnt;

    // slave image
    bit [7:0]  frame_mem[256];
    int        frame_len;
    bit [15:0] hold_regs[HOLDING_COUNT_DEF];
    bit [15:0] input_regs[INPUT_COUNT_DEF];
    bit [7:0]  station;

    modbus_rtu_register_slave u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_rx_byte  (s_rx_byte),
        .s_reg_index(s_reg_index),
        .s_reg_value(s_reg_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tx_byte  (m_tx_byte),
        .m_last_byte(m_last_byte)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tb_top failed");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic bit [15:0] word_at(input int pos);
        return {frame_mem[pos], frame_mem[pos + 1]};
    endfunction

    function automatic void push_reply(ref bit [7:0] tx[64], input int n);
        bit [15:0] c;
        reply_t r;
        c = 16'hFFFF;
        for (int i = 0; i < n; i++) begin
            c = c ^ {8'h00, tx[i]};
            for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        tx[n] = c[7:0];
        tx[n + 1] = c[15:8];
        for (int k = 0; k < n + 2; k++) begin
            r.data = tx[k];
            r.last = (k == n + 1);
            reply_q.push_back(r);
        end
    endfunction

    function automatic void reply_exception(input bit [7:0] code);
        bit [7:0] tx[64];
        tx[0] = frame_mem[0];
        tx[1] = frame_mem[1] | EXC_FLAG;
        tx[2] = code;
        push_reply(tx, 3);
    endfunction

    function automatic void reply_echo();
        bit [7:0] tx[64];
        for (int i = 0; i < 6; i++) tx[i] = frame_mem[i];
        push_reply(tx, 6);
    endfunction

    function automatic void reply_read(input bit rd_input);
        bit [7:0] tx[64];
        int start;
        int cnt;
        int size;
        bit [15:0] v;
        start = int'(word_at(2));
        cnt = int'(word_at(4));
        size = rd_input ? INPUT_COUNT_DEF : HOLDING_COUNT_DEF;
        if (start + cnt > size) begin
            reply_exception(EXC_BAD_ADDRESS);
            return;
        end
        tx[0] = frame_mem[0];
        tx[1] = frame_mem[1];
        tx[2] = 8'((cnt * 2) & 255);
        for (int i = 0; i < cnt; i++) begin
            v = rd_input ? input_regs[start + i] : hold_regs[start + i];
            tx[3 + 2 * i] = v[15:8];
            tx[4 + 2 * i] = v[7:0];
        end
        push_reply(tx, 3 + 2 * cnt);
    endfunction

    function automatic void serve_frame();
        int start;
        int cnt;
        if (frame_mem[0] != station) return;
        start = int'(word_at(2));
        cnt = int'(word_at(4));
        case (frame_mem[1])
            FN_RD_HOLD:  reply_read(1'b0);
            FN_RD_INPUT: reply_read(1'b1);
            FN_WR_ONE: begin
                if (start >= HOLDING_COUNT_DEF) begin
                    reply_exception(EXC_BAD_ADDRESS);
                end else begin
                    hold_regs[start] = word_at(4);
                    reply_echo();
                end
            end
            FN_WR_MULTI: begin
                if (cnt < 1 || cnt > MAX_WRITE_COUNT || int'(frame_mem[6]) != cnt * 2)
                    reply_exception(EXC_BAD_ADDRESS);
                else if (start + cnt > HOLDING_COUNT_DEF)
                    reply_exception(EXC_BAD_ADDRESS);
                else begin
                    for (int i = 0; i < cnt; i++) hold_regs[start + i] = word_at(7 + 2 * i);
                    reply_echo();
                end
            end
            default: reply_exception(EXC_BAD_FUNCTION);
        endcase
    endfunction

    function automatic void slave_accept(input item_t it);
        int want;
        if (it.op) begin
            if (it.idx < INPUT_COUNT_DEF) input_regs[it.idx] = it.val;
            return;
        end
        if (frame_len < 256) begin
            frame_mem[frame_len] = it.rx;
            frame_len++;
        end
        if (frame_len >= 8) begin
            want = (frame_mem[1] == FN_WR_MULTI) ? 9 + int'(frame_mem[6]) : 8;
            if (frame_len == want) begin
                serve_frame();
                frame_len = 0;
                return;
            end
        end
        if (frame_len >= 256) frame_len = 0;
    endfunction

    // driver
    always @(negedge aclk) begin
        item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pending_q.pop_front();
                s_valid <= 1'b1;
                s_op <= it.op;
                s_rx_byte <= it.rx;
                s_reg_index <= it.idx;
                s_reg_value <= it.val;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver with a long hold-off each time hold_seq changes
    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_cnt <= 400;
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        item_t it;
        reply_t r;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            it.op = s_op;
            it.rx = s_rx_byte;
            it.idx = s_reg_index;
            it.val = s_reg_value;
            slave_accept(it);
        end
        if (aresetn && m_valid && m_ready) begin
            if (reply_q.size() == 0) begin
                report("unexpected byte", int'(m_tx_byte), 0);
            end else begin
                r = reply_q.pop_front();
                if (m_tx_byte !== r.data) report("tx_byte", int'(m_tx_byte), int'(r.data));
                if (m_last_byte !== r.last) begin
                    report("last_byte", int'(m_last_byte), int'(r.last));
                end
            end
        end
    end

    task automatic put_byte(input bit [7:0] b);
        item_t it;
        it.op = 1'b0;
        it.rx = b;
        it.idx = 5'($urandom);
        it.val = 16'($urandom);
        pending_q.push_back(it);
        item_cnt++;
    endtask

    task automatic put_update(input bit [4:0] idx, input bit [15:0] val);
        item_t it;
        it.op = 1'b1;
        it.rx = 8'($urandom);
        it.idx = idx;
        it.val = val;
        pending_q.push_back(it);
        item_cnt++;
    endtask

    // address, function, two words, trailer bytes of random content
    task automatic put_frame(input bit [7:0] adr, input bit [7:0] fn,
                             input bit [15:0] w0, input bit [15:0] w1);
        put_byte(adr);
        put_byte(fn);
        put_byte(w0[15:8]);
        put_byte(w0[7:0]);
        put_byte(w1[15:8]);
        put_byte(w1[7:0]);
        put_byte(8'($urandom));
        put_byte(8'($urandom));
    endtask

    task automatic put_multi(input bit [7:0] adr, input bit [15:0] start,
                             input bit [15:0] cnt, input bit [7:0] nbytes);
        put_byte(adr);
        put_byte(FN_WR_MULTI);
        put_byte(start[15:8]);
        put_byte(start[7:0]);
        put_byte(cnt[15:8]);
        put_byte(cnt[7:0]);
        put_byte(nbytes);
        for (int i = 0; i < nbytes + 2; i++) put_byte(8'($urandom));
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !s_valid && reply_q.size() == 0);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_station(input bit [7:0] a);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= a;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        station = a;
    endtask

    task automatic random_frame();
        bit [7:0] adr;
        int pick;
        int cnt;
        adr = ($urandom_range(9) == 0) ? 8'($urandom) : station;
        pick = $urandom_range(19);
        if (pick < 4) begin
            put_frame(adr, FN_RD_HOLD, 16'($urandom_range(7)),
                      ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(7)));
        end else if (pick < 8) begin
            put_frame(adr, FN_RD_INPUT,
                      ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(8)),
                      16'($urandom_range(8)));
        end else if (pick < 11) begin
            put_frame(adr, FN_WR_ONE,
                      ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(7)),
                      16'($urandom));
        end else if (pick < 15) begin
            cnt = $urandom_range(1, 7);
            put_multi(adr, 16'($urandom_range(7)), 16'(cnt),
                      ($urandom_range(7) == 0) ? 8'($urandom_range(16)) : 8'(cnt * 2));
        end else if (pick < 16) begin
            put_multi(adr, 16'($urandom), 16'($urandom), 8'($urandom_range(12)));
        end else if (pick < 18) begin
            put_frame(adr, ($urandom_range(1) == 0) ? 8'h11 : 8'($urandom | 8'h20),
                      16'($urandom), 16'($urandom));
        end else begin
            for (int i = 0; i < 3; i++)
                put_update(($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7)),
                           16'($urandom));
        end
    endtask

    task automatic random_phase(input int n);
        item_cnt = 0;
        while (item_cnt < n) random_frame();
        drain();
    endtask

    initial begin
        errors = 0;
        hold_seq = 0;
        hold_seen = 0;
        hold_cnt = 0;
        s_taken = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 73;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 8'h00;
        s_valid = 1'b0;
        s_op = 1'b0;
        s_rx_byte = 8'h00;
        s_reg_index = 5'd0;
        s_reg_value = 16'h0000;
        m_ready = 1'b0;
        frame_len = 0;
        station = 8'd1;
        for (int i = 0; i < HOLDING_COUNT_DEF; i++) hold_regs[i] = holding_rst(i);
        for (int i = 0; i < INPUT_COUNT_DEF; i++) input_regs[i] = 16'h0000;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed
        put_update(5'd0, 16'hFFFF);
        put_update(5'd7, 16'h8001);
        put_update(5'd31, 16'h1234);
        put_frame(8'd1, FN_RD_HOLD, 16'd0, 16'd7);
        put_frame(8'd1, FN_RD_INPUT, 16'd0, 16'd8);
        put_frame(8'd1, FN_RD_HOLD, 16'd3, 16'd0);
        put_frame(8'd1, FN_RD_INPUT, 16'hFFFF, 16'hFFFF);
        put_frame(8'd1, FN_WR_ONE, 16'd6, 16'hFFFF);
        put_frame(8'd1, FN_WR_ONE, 16'd7, 16'h0000);
        put_multi(8'd1, 16'd0, 16'd7, 8'd14);
        put_multi(8'd1, 16'd0, 16'd0, 8'd0);
        put_multi(8'd1, 16'd0, 16'd124, 8'd4);
        put_multi(8'd1, 16'd0, 16'd2, 8'd3);
        put_multi(8'd1, 16'd6, 16'd2, 8'd4);
        put_frame(8'd1, 8'hFF, 16'd0, 16'd1);
        put_frame(8'd2, FN_RD_HOLD, 16'd0, 16'd1);
        drain();

        // store overflow: announced length never reached
        put_multi(8'd1, 16'd0, 16'd1, 8'd255);
        drain();
        put_frame(8'd1, FN_RD_HOLD, 16'd0, 16'd7);
        drain();

        set_station(8'd247);
        random_phase(30);

        set_station(8'd0);
        send_idle_pct = 73;
        recv_idle_pct = 20;
        random_phase(40);

        set_station(8'd255);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_seq = hold_seq + 1;
        for (int i = 0; i < 4; i++) put_frame(8'd255, FN_RD_HOLD, 16'd0, 16'd7);
        drain();

        set_station(8'd1);
        random_phase(20);

        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

/* modbus_rtu_register_slave.f */
hw/rtl/mrs_pkg.sv
hw/rtl/mrs_ram.sv
hw/rtl/mrs_ctrl.sv
hw/rtl/mrs_dp.sv
hw/rtl/modbus_rtu_register_slave.sv
tb/sv/tb_top.sv
